// File: hdl/silu_pkg.sv
package silu_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int DIM_W  = 7;
  localparam int ACC_W  = 40;

  typedef logic [1:0] code_t;

  localparam code_t ST_OK   = 2'd0;
  localparam code_t ST_SAT  = 2'd1;
  localparam code_t ST_ZERO = 2'd2;
  localparam code_t ST_BAD  = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE, S_FIN, S_FCHK,
    S_FI, S_FI1, S_FI2, S_FP, S_FP1, S_FK1, S_FK2,
    S_FS, S_FS1, S_DG1, S_DG2, S_DW,
    S_FQ, S_FQ1, S_U1, S_U2, S_U3,
    S_SF, S_SF1, S_SF2, S_SFP, S_SFP1, S_SFP2, S_SFP3, S_SFP4,
    S_SB, S_SB1, S_SB2, S_SB3, S_SBP, S_SBP1, S_SBP2, S_SBP3, S_SBP4,
    S_SBX, S_SBD, S_SBW,
    S_E0, S_E1, S_EZ
  } state_t;

  typedef enum logic [1:0] {VW_INPUT, VW_QUOT, VW_DIFF} val_src_t;
  typedef enum logic [1:0] {MS_FACTOR, MS_FWD, MS_BWD} mul_src_t;
  typedef enum logic {DS_FACTOR, DS_BWD} div_src_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_WV, ACC_Y, ACC_SUB} acc_op_t;

  typedef struct packed {
    logic     rs_we;
    logic     col_we;
    logic     val_we;
    val_src_t val_src;
    logic     wv_we;
    logic     y_we;
    logic     x_we;
    logic     b_load;
    logic     b_clear;
    logic     ap_load;
    mul_src_t mul_src;
    logic     div_go;
    div_src_t div_src;
    acc_op_t  acc_op;
    logic     sol_zero;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] col_rd;
    logic             mul_sat;
    logic             sub_sat;
    logic             acc_sat;
    logic             div_done;
    logic             div_sat;
    logic             div_zero;
  } stat_t;

  function automatic code_t raise(code_t cur, code_t code);
    return (code > cur) ? code : cur;
  endfunction

endpackage

// File: hdl/silu_div.sv
module silu_div
  import silu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     done,
  output logic signed [DATA_W-1:0] q,
  output logic                     sat,
  output logic                     zero
);

  localparam int NUM_W = DATA_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run;
  logic             fin;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DATA_W:0]  rem;
  logic [DATA_W-1:0] den;

  logic [DATA_W-1:0] ma;
  logic [DATA_W-1:0] mb;
  logic [DATA_W:0]   rem_s;
  logic              ge;
  logic [NUM_W-1:0]  start_num;

  assign ma = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign mb = b[DATA_W-1] ? (~b + 1'b1) : b;
  assign start_num = (NUM_W'(ma) << FRAC_BITS) + NUM_W'(mb >> 1);
  assign rem_s = {rem[DATA_W-1:0], num[NUM_W-1]};
  assign ge = rem_s >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        if (b == '0) begin
          q    <= '0;
          sat  <= 1'b0;
          zero <= 1'b1;
          done <= 1'b1;
        end else begin
          zero <= 1'b0;
          run  <= 1'b1;
          num  <= start_num;
          rem  <= '0;
          den  <= mb;
          neg  <= a[DATA_W-1] ^ b[DATA_W-1];
          cnt  <= CNT_W'(NUM_W);
        end
      end else if (run) begin
        rem <= ge ? (rem_s - {1'b0, den}) : rem_s;
        num <= {num[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (!neg) begin
          sat <= num > NUM_W'(32'h7fff_ffff);
          q   <= (num > NUM_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : num[DATA_W-1:0];
        end else begin
          sat <= num > NUM_W'(32'h8000_0000);
          q   <= (num > NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                               : (~num[DATA_W-1:0] + 1'b1);
        end
      end
    end
  end

endmodule

// File: hdl/silu_dp.sv
module silu_dp
  import silu_pkg::*;
#(
  parameter int MAX_DIM      = 64,
  parameter int MAX_NONZEROS = 1024,
  parameter int FRAC_BITS    = 16,
  localparam int RW = $clog2(MAX_DIM + 1),
  localparam int IW = $clog2(MAX_DIM),
  localparam int PW = $clog2(MAX_NONZEROS),
  localparam int CW = $clog2(MAX_NONZEROS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [RW-1:0]            rs_addr,
  input  logic [CW-1:0]            rs_wdata,
  output logic [CW-1:0]            rs_rd,
  input  logic [PW-1:0]            ent_addr,
  input  logic [IW-1:0]            vec_addr,
  input  logic [IDX_W-1:0]         column,
  input  logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] solution
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(33'sh0_8000_0000);

  logic [CW-1:0]            rs_mem  [0:MAX_DIM];
  logic [IDX_W-1:0]         col_mem [MAX_NONZEROS];
  logic signed [DATA_W-1:0] val_mem [MAX_NONZEROS];
  logic signed [DATA_W-1:0] wv_mem  [MAX_DIM];
  logic signed [DATA_W-1:0] y_mem   [MAX_DIM];
  logic signed [DATA_W-1:0] x_mem   [MAX_DIM];

  logic [IDX_W-1:0]         col_rd;
  logic signed [DATA_W-1:0] val_rd;
  logic signed [DATA_W-1:0] wv_rd;
  logic signed [DATA_W-1:0] y_rd;
  logic signed [DATA_W-1:0] x_rd;

  logic signed [DATA_W-1:0] opb;
  logic signed [DATA_W-1:0] ap;
  logic signed [ACC_W-1:0]  acc;
  logic signed [63:0]       prod;
  logic signed [DATA_W-1:0] mul_res;
  logic                     mul_sat;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic [63:0]              pmag;
  logic [63:0]              prnd;
  logic                     rnd_sat;
  logic signed [DATA_W-1:0] rnd_res;

  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] diff_s;
  logic                     diff_sat;
  logic signed [DATA_W-1:0] acc_s;
  logic                     acc_sat;

  logic signed [DATA_W-1:0] div_a;
  logic signed [DATA_W-1:0] div_b;
  logic signed [DATA_W-1:0] div_q;
  logic                     div_done;
  logic                     div_sat;
  logic                     div_zero;
  logic signed [DATA_W-1:0] val_wdata;

  always_comb begin
    unique case (cmd.mul_src)
      MS_FACTOR: begin
        mul_a = ap;
        mul_b = val_rd;
      end
      MS_FWD: begin
        mul_a = y_rd;
        mul_b = val_rd;
      end
      default: begin
        mul_a = val_rd;
        mul_b = x_rd;
      end
    endcase
  end

  always_comb begin
    pmag = prod[63] ? (~prod + 1'b1) : prod;
    prnd = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (!prod[63]) begin
      rnd_sat = prnd > 64'h7fff_ffff;
      rnd_res = rnd_sat ? 32'sh7fff_ffff : prnd[DATA_W-1:0];
    end else begin
      rnd_sat = prnd > 64'h8000_0000;
      rnd_res = rnd_sat ? 32'sh8000_0000 : (~prnd[DATA_W-1:0] + 1'b1);
    end
  end

  always_comb begin
    diff     = {val_rd[DATA_W-1], val_rd} - {mul_res[DATA_W-1], mul_res};
    diff_sat = diff[DATA_W] != diff[DATA_W-1];
    diff_s   = diff_sat ? (diff[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                        : diff[DATA_W-1:0];
  end

  always_comb begin
    acc_sat = (acc > ACC_MAX) || (acc < ACC_MIN);
    if (acc > ACC_MAX) begin
      acc_s = 32'sh7fff_ffff;
    end else if (acc < ACC_MIN) begin
      acc_s = 32'sh8000_0000;
    end else begin
      acc_s = acc[DATA_W-1:0];
    end
  end

  assign div_a = (cmd.div_src == DS_FACTOR) ? val_rd : acc_s;
  assign div_b = (cmd.div_src == DS_FACTOR) ? opb : val_rd;

  silu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .a    (div_a),
    .b    (div_b),
    .done (div_done),
    .q    (div_q),
    .sat  (div_sat),
    .zero (div_zero)
  );

  always_comb begin
    unique case (cmd.val_src)
      VW_INPUT: val_wdata = value;
      VW_QUOT:  val_wdata = div_q;
      default:  val_wdata = diff_s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rs_we) begin
      rs_mem[rs_addr] <= rs_wdata;
    end
    if (cmd.col_we) begin
      col_mem[ent_addr] <= column;
    end
    if (cmd.val_we) begin
      val_mem[ent_addr] <= val_wdata;
    end
    if (cmd.wv_we) begin
      wv_mem[vec_addr] <= value;
    end
    if (cmd.y_we) begin
      y_mem[vec_addr] <= acc_s;
    end
    if (cmd.x_we) begin
      x_mem[vec_addr] <= div_q;
    end
    rs_rd  <= rs_mem[rs_addr];
    col_rd <= col_mem[ent_addr];
    val_rd <= val_mem[ent_addr];
    wv_rd  <= wv_mem[vec_addr];
    y_rd   <= y_mem[vec_addr];
    x_rd   <= x_mem[vec_addr];
  end

  always_ff @(posedge clk) begin
    prod    <= mul_a * mul_b;
    mul_res <= rnd_res;
    mul_sat <= rnd_sat;
    if (cmd.b_clear) begin
      opb <= '0;
    end else if (cmd.b_load) begin
      opb <= val_rd;
    end
    if (cmd.ap_load) begin
      ap <= div_q;
    end
    unique case (cmd.acc_op)
      ACC_WV:  acc <= ACC_W'(wv_rd);
      ACC_Y:   acc <= ACC_W'(y_rd);
      ACC_SUB: acc <= acc - ACC_W'(mul_res);
      default: acc <= acc;
    endcase
  end

  assign stat.col_rd   = col_rd;
  assign stat.mul_sat  = mul_sat;
  assign stat.sub_sat  = diff_sat;
  assign stat.acc_sat  = acc_sat;
  assign stat.div_done = div_done;
  assign stat.div_sat  = div_sat;
  assign stat.div_zero = div_zero;

  assign solution = cmd.sol_zero ? '0 : x_rd;

endmodule

// File: hdl/silu_ctrl.sv
module silu_ctrl
  import silu_pkg::*;
#(
  parameter int MAX_DIM      = 64,
  parameter int MAX_NONZEROS = 1024,
  localparam int NW = $clog2(MAX_DIM + 1),
  localparam int RW = $clog2(MAX_DIM + 1),
  localparam int IW = $clog2(MAX_DIM),
  localparam int PW = $clog2(MAX_NONZEROS),
  localparam int CW = $clog2(MAX_NONZEROS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIM_W-1:0] dimension,
  input  logic             start,
  input  logic             op,
  input  logic [IDX_W-1:0] row,
  input  logic [IDX_W-1:0] column,
  input  logic             last,
  output logic             busy,
  output logic             strobe,
  output logic [IDX_W-1:0] index,
  output logic             final_res,
  output code_t            status,
  output cmd_t             cmd,
  input  stat_t            stat,
  input  logic [CW-1:0]    rs_rd,
  output logic [RW-1:0]    rs_addr,
  output logic [CW-1:0]    rs_wdata,
  output logic [PW-1:0]    ent_addr,
  output logic [IW-1:0]    vec_addr
);

  state_t           state, state_next;
  logic [NW-1:0]    n, n_next;
  logic             load_open, load_open_next;
  logic             ready, ready_next;
  logic [IDX_W-1:0] cur_row, cur_row_next;
  logic [IDX_W-1:0] last_col, last_col_next;
  logic             row_has, row_has_next;
  logic             diag_seen, diag_seen_next;
  logic [CW-1:0]    cnt, cnt_next;
  code_t            eflags, eflags_next;
  code_t            st, st_next;
  logic [NW-1:0]    i, i_next;
  logic [CW-1:0]    p, p_next;
  logic [CW-1:0]    pend, pend_next;
  logic [CW-1:0]    q, q_next;
  logic [CW-1:0]    s, s_next;
  logic [CW-1:0]    kst, kst_next;
  logic [CW-1:0]    kend, kend_next;
  logic [CW-1:0]    pst, pst_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] tc, tc_next;
  logic             ret_upd, ret_upd_next;

  logic [NW-1:0]    edim;
  logic             open_now;
  logic [NW-1:0]    b_n;
  logic [IDX_W-1:0] b_row;
  logic [IDX_W-1:0] b_last;
  logic             b_has;
  logic             b_diag;
  logic [CW-1:0]    b_cnt;
  code_t            b_fl;
  logic             bad;
  logic             adv;
  logic             skip;
  logic             full;
  logic             store;
  logic [7:0]       col8;
  logic [7:0]       i8;

  always_comb begin
    if (dimension == '0) begin
      edim = NW'(1);
    end else if (dimension > DIM_W'(MAX_DIM)) begin
      edim = NW'(MAX_DIM);
    end else begin
      edim = NW'(dimension);
    end
  end

  assign open_now = !load_open;
  assign b_n    = open_now ? edim : n;
  assign b_row  = open_now ? '0 : cur_row;
  assign b_last = open_now ? '0 : last_col;
  assign b_has  = open_now ? 1'b0 : row_has;
  assign b_diag = open_now ? 1'b0 : diag_seen;
  assign b_cnt  = open_now ? '0 : cnt;
  assign b_fl   = open_now ? ST_OK : eflags;

  assign bad = (8'(row) >= 8'(b_n)) || (8'(column) >= 8'(b_n)) || (row < b_row) ||
               ((row == b_row) && b_has && (column <= b_last));
  assign adv   = !bad && (row > b_row);
  assign skip  = 8'(row) > (8'(b_row) + 8'd1);
  assign full  = b_cnt >= CW'(MAX_NONZEROS);
  assign store = !bad && !full;

  assign col8 = 8'(stat.col_rd);
  assign i8   = 8'(i);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= NW'(MAX_DIM);
      load_open <= 1'b0;
      ready     <= 1'b0;
      cur_row   <= '0;
      last_col  <= '0;
      row_has   <= 1'b0;
      diag_seen <= 1'b0;
      cnt       <= '0;
      eflags    <= ST_OK;
      st        <= ST_OK;
      i         <= '0;
    end else begin
      state     <= state_next;
      n         <= n_next;
      load_open <= load_open_next;
      ready     <= ready_next;
      cur_row   <= cur_row_next;
      last_col  <= last_col_next;
      row_has   <= row_has_next;
      diag_seen <= diag_seen_next;
      cnt       <= cnt_next;
      eflags    <= eflags_next;
      st        <= st_next;
      i         <= i_next;
    end
  end

  always_ff @(posedge clk) begin
    p       <= p_next;
    pend    <= pend_next;
    q       <= q_next;
    s       <= s_next;
    kst     <= kst_next;
    kend    <= kend_next;
    pst     <= pst_next;
    k       <= k_next;
    tc      <= tc_next;
    ret_upd <= ret_upd_next;
  end

  always_comb begin
    state_next     = state;
    n_next         = n;
    load_open_next = load_open;
    ready_next     = ready;
    cur_row_next   = cur_row;
    last_col_next  = last_col;
    row_has_next   = row_has;
    diag_seen_next = diag_seen;
    cnt_next       = cnt;
    eflags_next    = eflags;
    st_next        = st;
    i_next         = i;
    p_next         = p;
    pend_next      = pend;
    q_next         = q;
    s_next         = s;
    kst_next       = kst;
    kend_next      = kend;
    pst_next       = pst;
    k_next         = k;
    tc_next        = tc;
    ret_upd_next   = ret_upd;

    cmd       = '0;
    rs_addr   = '0;
    rs_wdata  = cnt;
    ent_addr  = '0;
    vec_addr  = '0;
    strobe    = 1'b0;
    index     = IDX_W'(i);
    final_res = (i + 1'b1) == n;
    status    = st;

    unique case (state)
      S_IDLE: begin
        if (start && !op) begin
          n_next = b_n;
          if (open_now) begin
            ready_next = 1'b0;
          end
          eflags_next = b_fl;
          if (bad || (adv && (!b_diag || skip)) || (!bad && full)) begin
            eflags_next = ST_BAD;
          end
          cur_row_next   = adv ? row : b_row;
          row_has_next   = store ? 1'b1 : (adv ? 1'b0 : b_has);
          diag_seen_next = (store && (column == row)) ? 1'b1 : (adv ? 1'b0 : b_diag);
          last_col_next  = store ? column : b_last;
          cnt_next       = store ? (b_cnt + 1'b1) : b_cnt;
          cmd.rs_we  = adv || open_now;
          rs_addr    = adv ? RW'(8'(b_row) + 8'd1) : '0;
          rs_wdata   = b_cnt;
          cmd.col_we = store;
          cmd.val_we = store;
          cmd.val_src = VW_INPUT;
          ent_addr   = b_cnt[PW-1:0];
          if (last) begin
            load_open_next = 1'b0;
            state_next     = S_FIN;
          end else begin
            load_open_next = 1'b1;
          end
        end else if (start && op) begin
          cmd.wv_we = 8'(row) < 8'(n);
          vec_addr  = row[IW-1:0];
          if (last) begin
            i_next = '0;
            if (ready) begin
              st_next    = eflags;
              state_next = S_SF;
            end else begin
              state_next = S_EZ;
            end
          end
        end
      end

      S_FIN: begin
        cmd.rs_we = 1'b1;
        rs_addr   = RW'(8'(cur_row) + 8'd1);
        rs_wdata  = cnt;
        if (!diag_seen || (8'(n) > (8'(cur_row) + 8'd1))) begin
          eflags_next = ST_BAD;
        end
        state_next = S_FCHK;
      end

      S_FCHK: begin
        if (eflags == ST_BAD) begin
          ready_next = 1'b0;
          state_next = S_IDLE;
        end else begin
          i_next     = NW'(1);
          state_next = S_FI;
        end
      end

      S_FI: begin
        if (i >= n) begin
          ready_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          rs_addr    = RW'(i);
          state_next = S_FI1;
        end
      end

      S_FI1: begin
        p_next     = rs_rd;
        rs_addr    = RW'(i8 + 8'd1);
        state_next = S_FI2;
      end

      S_FI2: begin
        pend_next  = rs_rd;
        state_next = S_FP;
      end

      S_FP: begin
        if (p >= pend) begin
          i_next     = i + 1'b1;
          state_next = S_FI;
        end else begin
          ent_addr   = p[PW-1:0];
          state_next = S_FP1;
        end
      end

      S_FP1: begin
        if (col8 >= i8) begin
          i_next     = i + 1'b1;
          state_next = S_FI;
        end else begin
          k_next     = stat.col_rd;
          rs_addr    = RW'(stat.col_rd);
          state_next = S_FK1;
        end
      end

      S_FK1: begin
        kst_next   = rs_rd;
        rs_addr    = RW'(8'(k) + 8'd1);
        state_next = S_FK2;
      end

      S_FK2: begin
        kend_next    = rs_rd;
        s_next       = kst;
        tc_next      = k;
        ret_upd_next = 1'b0;
        state_next   = S_FS;
      end

      S_FS: begin
        if (s >= kend) begin
          if (ret_upd) begin
            q_next     = q + 1'b1;
            state_next = S_FQ;
          end else begin
            cmd.b_clear = 1'b1;
            ent_addr    = p[PW-1:0];
            state_next  = S_DG2;
          end
        end else begin
          ent_addr   = s[PW-1:0];
          state_next = S_FS1;
        end
      end

      S_FS1: begin
        if (stat.col_rd == tc) begin
          ent_addr   = s[PW-1:0];
          state_next = ret_upd ? S_U1 : S_DG1;
        end else begin
          s_next     = s + 1'b1;
          state_next = S_FS;
        end
      end

      S_DG1: begin
        cmd.b_load = 1'b1;
        ent_addr   = p[PW-1:0];
        state_next = S_DG2;
      end

      S_DG2: begin
        cmd.div_go  = 1'b1;
        cmd.div_src = DS_FACTOR;
        state_next  = S_DW;
      end

      S_DW: begin
        if (stat.div_done) begin
          cmd.val_we  = 1'b1;
          cmd.val_src = VW_QUOT;
          cmd.ap_load = 1'b1;
          ent_addr    = p[PW-1:0];
          if (stat.div_zero) begin
            eflags_next = raise(eflags, ST_ZERO);
          end else if (stat.div_sat) begin
            eflags_next = raise(eflags, ST_SAT);
          end
          q_next     = p + 1'b1;
          state_next = S_FQ;
        end
      end

      S_FQ: begin
        if (q >= pend) begin
          p_next     = p + 1'b1;
          state_next = S_FP;
        end else begin
          ent_addr   = q[PW-1:0];
          state_next = S_FQ1;
        end
      end

      S_FQ1: begin
        tc_next      = stat.col_rd;
        s_next       = kst;
        ret_upd_next = 1'b1;
        state_next   = S_FS;
      end

      S_U1: begin
        cmd.mul_src = MS_FACTOR;
        ent_addr    = q[PW-1:0];
        state_next  = S_U2;
      end

      S_U2: begin
        ent_addr   = q[PW-1:0];
        state_next = S_U3;
      end

      S_U3: begin
        cmd.val_we  = 1'b1;
        cmd.val_src = VW_DIFF;
        ent_addr    = q[PW-1:0];
        if (stat.mul_sat || stat.sub_sat) begin
          eflags_next = raise(eflags, ST_SAT);
        end
        q_next     = q + 1'b1;
        state_next = S_FQ;
      end

      S_SF: begin
        if (i >= n) begin
          i_next     = n - 1'b1;
          state_next = S_SB;
        end else begin
          vec_addr   = i[IW-1:0];
          rs_addr    = RW'(i);
          state_next = S_SF1;
        end
      end

      S_SF1: begin
        cmd.acc_op = ACC_WV;
        p_next     = rs_rd;
        rs_addr    = RW'(i8 + 8'd1);
        state_next = S_SF2;
      end

      S_SF2: begin
        pend_next  = rs_rd;
        state_next = S_SFP;
      end

      S_SFP: begin
        if (p >= pend) begin
          cmd.y_we = 1'b1;
          vec_addr = i[IW-1:0];
          if (stat.acc_sat) begin
            st_next = raise(st, ST_SAT);
          end
          i_next     = i + 1'b1;
          state_next = S_SF;
        end else begin
          ent_addr   = p[PW-1:0];
          state_next = S_SFP1;
        end
      end

      S_SFP1: begin
        if (col8 >= i8) begin
          cmd.y_we = 1'b1;
          vec_addr = i[IW-1:0];
          if (stat.acc_sat) begin
            st_next = raise(st, ST_SAT);
          end
          i_next     = i + 1'b1;
          state_next = S_SF;
        end else begin
          vec_addr   = stat.col_rd[IW-1:0];
          ent_addr   = p[PW-1:0];
          state_next = S_SFP2;
        end
      end

      S_SFP2: begin
        cmd.mul_src = MS_FWD;
        state_next  = S_SFP3;
      end

      S_SFP3: begin
        state_next = S_SFP4;
      end

      S_SFP4: begin
        cmd.acc_op = ACC_SUB;
        if (stat.mul_sat) begin
          st_next = raise(st, ST_SAT);
        end
        p_next     = p + 1'b1;
        state_next = S_SFP;
      end

      S_SB: begin
        rs_addr    = RW'(i);
        state_next = S_SB1;
      end

      S_SB1: begin
        pst_next   = rs_rd;
        rs_addr    = RW'(i8 + 8'd1);
        state_next = S_SB2;
      end

      S_SB2: begin
        p_next     = rs_rd;
        vec_addr   = i[IW-1:0];
        state_next = S_SB3;
      end

      S_SB3: begin
        cmd.acc_op = ACC_Y;
        state_next = S_SBP;
      end

      S_SBP: begin
        if (p > pst) begin
          ent_addr   = PW'(p - 1'b1);
          state_next = S_SBP1;
        end else begin
          state_next = S_SBX;
        end
      end

      S_SBP1: begin
        if (col8 > i8) begin
          p_next     = p - 1'b1;
          ent_addr   = PW'(p - 1'b1);
          vec_addr   = stat.col_rd[IW-1:0];
          state_next = S_SBP2;
        end else begin
          state_next = S_SBX;
        end
      end

      S_SBP2: begin
        cmd.mul_src = MS_BWD;
        state_next  = S_SBP3;
      end

      S_SBP3: begin
        state_next = S_SBP4;
      end

      S_SBP4: begin
        cmd.acc_op = ACC_SUB;
        if (stat.mul_sat) begin
          st_next = raise(st, ST_SAT);
        end
        state_next = S_SBP;
      end

      S_SBX: begin
        ent_addr   = (p > pst) ? PW'(p - 1'b1) : p[PW-1:0];
        state_next = S_SBD;
      end

      S_SBD: begin
        cmd.div_go  = 1'b1;
        cmd.div_src = DS_BWD;
        if (stat.acc_sat) begin
          st_next = raise(st, ST_SAT);
        end
        state_next = S_SBW;
      end

      S_SBW: begin
        if (stat.div_done) begin
          cmd.x_we = 1'b1;
          vec_addr = i[IW-1:0];
          if (stat.div_zero) begin
            st_next = raise(st, ST_ZERO);
          end else if (stat.div_sat) begin
            st_next = raise(st, ST_SAT);
          end
          if (i == '0) begin
            state_next = S_E0;
          end else begin
            i_next     = i - 1'b1;
            state_next = S_SB;
          end
        end
      end

      S_E0: begin
        vec_addr   = i[IW-1:0];
        state_next = S_E1;
      end

      S_E1: begin
        strobe = 1'b1;
        if ((i + 1'b1) == n) begin
          state_next = S_IDLE;
        end else begin
          i_next     = i + 1'b1;
          state_next = S_E0;
        end
      end

      S_EZ: begin
        strobe       = 1'b1;
        cmd.sol_zero = 1'b1;
        status       = ST_BAD;
        if ((i + 1'b1) == n) begin
          state_next = S_IDLE;
        end else begin
          i_next = i + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;

endmodule

// File: hdl/sparse_ilu0_factor_and_solve_top.sv
// Channel     Signals                                   Handshake
// config      cfg_we, cfg_data                          write when cfg_we high
// request     start, op, row, column, value, last       taken when start && !busy
// result      strobe, index, solution, final_res,       one cycle per strobe
//             status
//
// Matrix entries and right-hand-side elements are taken one per cycle while busy is low.
// A final matrix entry holds busy through ILU(0) factorization: per lower entry a
// divide plus a linear column search of the pivot row per later entry.
// A final right-hand-side element holds busy through both triangular solves
// (a multiply per off-diagonal term, a divide per row), then emits one result
// per pass through S_E0 and S_E1; without a usable matrix, one zero result per cycle.
// Synchronous reset; results cannot be stalled.
module sparse_ilu0_factor_and_solve_top
  import silu_pkg::*;
#(
  parameter int MAX_DIM      = 64,
  parameter int MAX_NONZEROS = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         column,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     strobe,
  output logic [IDX_W-1:0]         index,
  output logic signed [DATA_W-1:0] solution,
  output logic                     final_res,
  output code_t                    status
);

  localparam int RW = $clog2(MAX_DIM + 1);
  localparam int IW = $clog2(MAX_DIM);
  localparam int PW = $clog2(MAX_NONZEROS);
  localparam int CW = $clog2(MAX_NONZEROS + 1);

  logic [DIM_W-1:0] dimension;
  cmd_t             cmd;
  stat_t            stat;
  logic [CW-1:0]    rs_rd;
  logic [RW-1:0]    rs_addr;
  logic [CW-1:0]    rs_wdata;
  logic [PW-1:0]    ent_addr;
  logic [IW-1:0]    vec_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= 7'd64;
    end else if (cfg_we) begin
      dimension <= cfg_data;
    end
  end

  silu_ctrl #(
    .MAX_DIM      (MAX_DIM),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .dimension (dimension),
    .start     (start),
    .op        (op),
    .row       (row),
    .column    (column),
    .last      (last),
    .busy      (busy),
    .strobe    (strobe),
    .index     (index),
    .final_res (final_res),
    .status    (status),
    .cmd       (cmd),
    .stat      (stat),
    .rs_rd     (rs_rd),
    .rs_addr   (rs_addr),
    .rs_wdata  (rs_wdata),
    .ent_addr  (ent_addr),
    .vec_addr  (vec_addr)
  );

  silu_dp #(
    .MAX_DIM      (MAX_DIM),
    .MAX_NONZEROS (MAX_NONZEROS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .rs_addr  (rs_addr),
    .rs_wdata (rs_wdata),
    .rs_rd    (rs_rd),
    .ent_addr (ent_addr),
    .vec_addr (vec_addr),
    .column   (column),
    .value    (value),
    .solution (solution)
  );

endmodule

// File: dv/silu_solution_checker.sv
module silu_solution_checker
  import silu_pkg::*;
#(
  parameter int MAX_DIM      = 64,
  parameter int MAX_NONZEROS = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     op,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         column,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  input  logic                     strobe,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [DATA_W-1:0] solution,
  input  logic                     final_res,
  input  code_t                    status,
  output int                       fail_count,
  output int                       pending,
  output int                       request_count,
  output int                       result_count,
  output int                       solve_count
);

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] sol;
    logic             fin;
    code_t            st;
  } sol_t;

  sol_t solution_q[$];

  logic [DIM_W-1:0] dim_reg;
  int unsigned      rs[0:MAX_DIM];
  logic [IDX_W-1:0] cs[0:MAX_NONZEROS-1];
  int               es[0:MAX_NONZEROS-1];
  int               wv[0:MAX_DIM-1];
  int               xv[0:MAX_DIM-1];
  int unsigned      nnz;
  code_t            mflags;
  bit               loading;
  bit               ready;
  int unsigned      n_lat;
  int unsigned      cur_r;
  int unsigned      last_c;
  bit               row_any;
  bit               diag_ok;

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic code_t bump(code_t cur, code_t code);
    return (code > cur) ? code : cur;
  endfunction

  function automatic int clip32(longint v, inout code_t f);
    if (v > 64'sd2147483647) begin
      f = bump(f, ST_SAT);
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      f = bump(f, ST_SAT);
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic int fx_mul(int a, int b, inout code_t f);
    longint p;
    longint m;
    p = longint'(a) * longint'(b);
    m = ((p < 0) ? -p : p);
    m = (m + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clip32((p < 0) ? -m : m, f);
  endfunction

  function automatic int fx_div(int a, int b, inout code_t f);
    longint ma;
    longint mb;
    longint q;
    if (b == 0) begin
      f = bump(f, ST_ZERO);
      return 0;
    end
    ma = (a < 0) ? -longint'(a) : longint'(a);
    mb = (b < 0) ? -longint'(b) : longint'(b);
    q = ((ma <<< FRAC_BITS) + mb / 2) / mb;
    return clip32(((a < 0) != (b < 0)) ? -q : q, f);
  endfunction

  function automatic int find_pos(int unsigned r, int unsigned c);
    for (int unsigned p = rs[r]; p < rs[r+1] && p < MAX_NONZEROS; p++)
      if (cs[p] == c) return p;
    return -1;
  endfunction

  function automatic void ilu_factor();
    int unsigned fin;
    int unsigned k;
    int dk;
    int kj;
    int piv;
    int pr;
    for (int unsigned i = 1; i < n_lat; i++) begin
      fin = rs[i+1];
      for (int unsigned p = rs[i]; p < fin && cs[p] < i; p++) begin
        k = cs[p];
        dk = find_pos(k, k);
        piv = (dk >= 0) ? es[dk] : 0;
        es[p] = fx_div(es[p], piv, mflags);
        for (int unsigned q = p + 1; q < fin; q++) begin
          kj = find_pos(k, cs[q]);
          if (kj >= 0) begin
            pr = fx_mul(es[p], es[kj], mflags);
            es[q] = clip32(longint'(es[q]) - longint'(pr), mflags);
          end
        end
      end
    end
  endfunction

  function automatic void close_rows(int unsigned upto);
    if (!diag_ok) mflags = bump(mflags, ST_BAD);
    if (upto > cur_r + 1) mflags = bump(mflags, ST_BAD);
    for (int unsigned q = cur_r + 1; q <= upto && q <= MAX_DIM; q++)
      rs[q] = nnz;
  endfunction

  function automatic void load_entry(int unsigned r, int unsigned c, int v);
    if (r >= n_lat || c >= n_lat || r < cur_r || (r == cur_r && row_any && c <= last_c)) begin
      mflags = bump(mflags, ST_BAD);
      return;
    end
    if (r > cur_r) begin
      close_rows(r);
      cur_r = r;
      row_any = 0;
      diag_ok = 0;
    end
    if (nnz >= MAX_NONZEROS) begin
      mflags = bump(mflags, ST_BAD);
      return;
    end
    cs[nnz] = c;
    es[nnz] = v;
    nnz++;
    row_any = 1;
    last_c = c;
    if (c == r) diag_ok = 1;
  endfunction

  function automatic void tri_solve();
    int    y[0:MAX_DIM-1];
    code_t st;
    longint acc;
    int unsigned p;
    sol_t  s;
    st = mflags;
    if (ready) begin
      for (int unsigned i = 0; i < n_lat; i++) begin
        acc = wv[i];
        for (p = rs[i]; p < rs[i+1] && cs[p] < i; p++)
          acc -= fx_mul(y[cs[p]], es[p], st);
        y[i] = clip32(acc, st);
      end
      for (int i = n_lat - 1; i >= 0; i--) begin
        acc = y[i];
        p = rs[i+1];
        while (p > rs[i] && cs[p-1] > i) begin
          p--;
          acc -= fx_mul(es[p], xv[cs[p]], st);
        end
        if (p > rs[i]) p = p - 1;
        xv[i] = fx_div(clip32(acc, st), es[p], st);
      end
    end
    for (int unsigned i = 0; i < n_lat; i++) begin
      s.idx = i;
      s.sol = ready ? xv[i] : 0;
      s.fin = (i + 1 == n_lat);
      s.st  = ready ? st : ST_BAD;
      solution_q.push_back(s);
    end
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  always @(posedge clk) begin
    sol_t e;
    if (rst) begin
      solution_q.delete();
      dim_reg       = 64;
      nnz           = 0;
      mflags        = ST_OK;
      loading       = 0;
      ready         = 0;
      n_lat         = eff_dim(64);
      cur_r         = 0;
      last_c        = 0;
      row_any       = 0;
      diag_ok       = 0;
      fail_count    = 0;
      request_count = 0;
      result_count  = 0;
      solve_count   = 0;
    end else begin
      if (cfg_we) dim_reg = cfg_data;
      if (strobe) begin
        result_count++;
        if (solution_q.size() == 0) begin
          note_fail($sformatf("result index %0d with nothing expected", index));
        end else begin
          e = solution_q.pop_front();
          if (index !== e.idx || solution !== e.sol || final_res !== e.fin || status !== e.st)
            note_fail($sformatf("exp idx %0d sol %h fin %0d st %0d, got idx %0d sol %h fin %0d st %0d",
                                e.idx, e.sol, e.fin, e.st, index, solution, final_res, status));
        end
      end
      if (start && !busy) begin
        request_count++;
        if (op == 1'b0) begin
          if (!loading) begin
            loading = 1;
            ready   = 0;
            n_lat   = eff_dim(dim_reg);
            nnz     = 0;
            mflags  = ST_OK;
            rs[0]   = 0;
            cur_r   = 0;
            last_c  = 0;
            row_any = 0;
            diag_ok = 0;
          end
          load_entry(row, column, value);
          if (last) begin
            close_rows(n_lat);
            loading = 0;
            if (mflags != ST_BAD) ilu_factor();
            ready = (mflags != ST_BAD);
          end
        end else begin
          if (row < n_lat) wv[row] = value;
          if (last) begin
            solve_count++;
            tri_solve();
          end
        end
      end
    end
    pending = solution_q.size();
  end

  final begin
    if (solution_q.size() != 0) $display("MISMATCH: %0d results never arrived", solution_q.size());
  end

endmodule

// File: dv/tb_sparse_ilu0_factor_and_solve_top.sv
module tb_sparse_ilu0_factor_and_solve_top;
  import silu_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [DIM_W-1:0]         cfg_data;
  logic                     start;
  logic                     busy;
  logic                     op;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         column;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic                     strobe;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] solution;
  logic                     final_res;
  code_t                    status;

  int fail_count;
  int pending;
  int request_count;
  int result_count;
  int solve_count;

  int          n_items;
  int          base_items;
  bit          quiet;
  int unsigned cur_dim;
  int          er[$];
  int          ec[$];
  int          ev[$];

  sparse_ilu0_factor_and_solve_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .op(op), .row(row), .column(column),
    .value(value), .last(last), .strobe(strobe), .index(index),
    .solution(solution), .final_res(final_res), .status(status)
  );

  silu_solution_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .op(op), .row(row), .column(column),
    .value(value), .last(last), .strobe(strobe), .index(index),
    .solution(solution), .final_res(final_res), .status(status),
    .fail_count(fail_count), .pending(pending), .request_count(request_count),
    .result_count(result_count), .solve_count(solve_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("Simulation FAILED");
    $finish;
  end

  // issue one request and hold it until taken
  task automatic put(bit o, int r, int c, int v, bit l);
    start  <= 1;
    op     <= o;
    row    <= r[IDX_W-1:0];
    column <= c[IDX_W-1:0];
    value  <= v;
    last   <= l;
    do @(posedge clk); while (busy);
    n_items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic set_dim(int d);
    start <= 0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1;
    cfg_data <= d[DIM_W-1:0];
    @(posedge clk);
    cfg_we  <= 0;
    cur_dim = (d[DIM_W-1:0] == 0) ? 1 : (d[DIM_W-1:0] > 64) ? 64 : d[DIM_W-1:0];
  endtask

  task automatic build(int n, bit wild, int prob, int full_rows);
    int v;
    er.delete();
    ec.delete();
    ev.delete();
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i == j || i < full_rows || $urandom_range(0, 99) < prob) begin
          if (wild) v = $urandom;
          else if (i == j) v = ((n + $urandom_range(1, 4)) << 16) + $urandom_range(0, 65535);
          else v = int'($urandom_range(0, 131071)) - 65536;
          er.push_back(i);
          ec.push_back(j);
          ev.push_back(v);
        end
  endtask

  task automatic zero_pivot(int n);
    int r;
    r = $urandom_range(0, n - 1);
    foreach (er[k])
      if (er[k] == r && ec[k] == r) ev[k] = 0;
  endtask

  task automatic corrupt(int n);
    int how;
    int k;
    int r;
    how = $urandom_range(0, 3);
    k = $urandom_range(0, er.size() - 1);
    r = $urandom_range(0, n - 1);
    case (how)
      0: begin
        for (int q = er.size() - 1; q >= 0; q--)
          if (er[q] == r && ec[q] == r) begin
            er.delete(q); ec.delete(q); ev.delete(q);
          end
      end
      1: begin
        for (int q = er.size() - 1; q >= 0; q--)
          if (er[q] == r) begin
            er.delete(q); ec.delete(q); ev.delete(q);
          end
      end
      2: begin
        er.insert(k + 1, er[k]); ec.insert(k + 1, ec[k]); ev.insert(k + 1, $urandom);
      end
      default: begin
        if (n < 64) begin
          if ($urandom_range(0, 1) == 0) begin
            er.insert(k + 1, er[k]); ec.insert(k + 1, 63);
          end else begin
            er.insert(k, 63); ec.insert(k, 0);
          end
          ev.insert(k, $urandom);
        end else if (k > 0 && er[k] > 0) begin
          er.insert(k + 1, 0); ec.insert(k + 1, 63); ev.insert(k + 1, $urandom);
        end else begin
          er.insert(k + 1, er[k]); ec.insert(k + 1, ec[k]); ev.insert(k + 1, $urandom);
        end
      end
    endcase
  endtask

  task automatic send_matrix(bit close);
    if (er.size() == 0) begin
      put(0, 0, 0, 0, close);
    end else begin
      foreach (er[k]) put(0, er[k], ec[k], ev[k], close && (k == er.size() - 1));
    end
  endtask

  task automatic send_rhs(int n, bit wild);
    int perm[64];
    int j;
    int t;
    int v;
    bit tail;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    tail = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < n; i++) begin
      v = wild ? int'($urandom) : int'($urandom_range(0, 20 << 16)) - (10 << 16);
      if (n < 64 && $urandom_range(0, 7) == 0) put(1, $urandom_range(n, 63), 0, $urandom, 0);
      put(1, perm[i], $urandom, v, tail && (i == n - 1));
    end
    if (!tail) put(1, $urandom_range(0, 63), $urandom, $urandom, 1);
  endtask

  task automatic one_round();
    int pick;
    int kind;
    int prob;
    if ($urandom_range(0, 4) == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) set_dim($urandom_range(1, 6));
      else if (pick < 9) set_dim($urandom_range(0, 1) ? 0 : 1);
      else set_dim($urandom_range(7, 12));
    end
    prob = (cur_dim <= 8) ? 40 : 2;
    kind = $urandom_range(0, 11);
    if (kind == 11) begin
      repeat ($urandom_range(1, 3)) put(1, $urandom_range(0, 63), $urandom, $urandom, 0);
      return;
    end
    build(cur_dim, kind == 6, prob, 0);
    if (kind == 7 || kind == 8) zero_pivot(cur_dim);
    if (kind >= 9) corrupt(cur_dim);
    send_matrix(1);
    repeat ($urandom_range(1, 2)) send_rhs(cur_dim, kind == 6 || $urandom_range(0, 9) == 0);
  endtask

  initial begin
    rst      = 1;
    cfg_we   = 0;
    cfg_data = 0;
    start    = 0;
    op       = 0;
    row      = 0;
    column   = 0;
    value    = 0;
    last     = 0;
    n_items  = 0;
    quiet    = 0;
    cur_dim  = 64;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_dim(0);
    put(1, 0, 0, 32'h12345678, 1);
    put(0, 0, 0, 32'sh80000000, 1);
    put(1, 0, 63, 32'sh7fffffff, 1);
    put(0, 0, 0, 0, 1);
    put(1, 0, 0, 32'sh00010000, 1);
    set_dim(2);
    build(2, 0, 100, 0);
    ev[0] = 0;
    send_matrix(1);
    send_rhs(2, 0);
    put(0, 0, 0, 32'sh00020000, 0);
    put(0, 1, 0, 32'sh00010000, 0);
    put(0, 1, 1, 32'sh7fffffff, 1);
    send_rhs(2, 1);
    put(0, 0, 0, 32'sh00010000, 0);
    put(1, 0, 0, 32'sh00010000, 0);
    put(1, 1, 0, 32'sh00010000, 1);
    build(2, 0, 100, 0);
    send_matrix(1);
    send_rhs(2, 0);

    set_dim(127);
    build(64, 0, 0, 0);
    send_matrix(1);
    send_rhs(64, 0);
    set_dim($urandom_range(1, 6));

    base_items = n_items;
    while (n_items < base_items + 120) begin
      quiet = (n_items > base_items + 80);
      one_round();
    end

    start <= 0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered %0d requests, %0d solves and %0d solution results,",
             request_count, solve_count, result_count);
    $display("including saturation, zero pivots, malformed loads and clamped sizes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
